>>> src/sse_pkg.sv
// sse_pkg: shared types and constants of the silhouette score engine
// command and status structs between controller and datapath
// no dependencies
package sse_pkg;

    // fixed field widths of the item ports
    localparam int FIELD_W = 16;
    localparam int LABEL_W = 4;
    localparam int CFG_W   = 5;

    // cluster table index selection
    localparam logic [1:0] IX_IN   = 2'd0;
    localparam logic [1:0] IX_OWN  = 2'd1;
    localparam logic [1:0] IX_C    = 2'd2;
    localparam logic [1:0] IX_LABJ = 2'd3;

    // divider operand selection
    localparam logic [1:0] DV_SUM   = 2'd0;
    localparam logic [1:0] DV_SCORE = 2'd1;
    localparam logic [1:0] DV_MEAN  = 2'd2;
    localparam logic [1:0] DV_TOTAL = 2'd3;

    typedef struct packed {
        logic       load;
        logic       i_clr;
        logic       i_inc;
        logic       rd_i;
        logic       rd_j;
        logic       cap_i;
        logic       cap_j;
        logic       j_clr;
        logic       sq;
        logic       sqrt_go;
        logic       acc;
        logic       div_go;
        logic [1:0] div_sel;
        logic       a_cap;
        logic       b_zero;
        logic       b_cap;
        logic       c_clr;
        logic       c_inc;
        logic       s_spec;
        logic       s_div;
        logic       tot_clr;
        logic       m_cap;
        logic       m_zero;
        logic       t_cap;
        logic       run_clr;
        logic [1:0] idx_sel;
    } t_cmd;

    typedef struct packed {
        logic i_end;
        logic j_end;
        logic c_end;
        logic own_skip;
        logic c_is_own;
        logic c_empty;
        logic one_cluster;
        logic trivial;
        logic sqrt_done;
        logic div_done;
        logic out_taken;
    } t_sts;

endpackage

>>> src/silhouette_score_engine.sv
// Silhouette score engine: points load at one item per cycle with no stall.
// The item marked last stalls the input through the pairwise distances of the
// shared bit-serial square root and the divisions in the shared divider,
// then num_clusters+1 results.
// Synchronous active-low reset empties the point set and sets num_clusters 1.
module silhouette_score_engine
    import sse_pkg::*;
#(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [FIELD_W-1:0] i_point_x,
    input  logic signed [FIELD_W-1:0] i_point_y,
    input  logic [LABEL_W-1:0]        i_point_cluster,
    input  logic                      i_last_point,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_result_kind,
    output logic [LABEL_W-1:0]        o_cluster_index,
    output logic signed [FIELD_W-1:0] o_score,
    output logic                      o_dropped,
    output logic                      o_last_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    // register writes always taken
    assign o_cfg_ready = 1'b1;

    sse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_point (i_last_point),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_in_stall   (o_in_stall)
    );

    sse_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_point_cluster (i_point_cluster),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_result_kind   (o_result_kind),
        .o_cluster_index (o_cluster_index),
        .o_score         (o_score),
        .o_dropped       (o_dropped),
        .o_last_result   (o_last_result)
    );

endmodule

>>> src/sse_sqrt.sv
// sse_sqrt: iterative integer square root, one root bit per cycle
// no package dependencies
module sse_sqrt #(
    parameter int RW = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_radicand,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int CW = $clog2(RW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [2*RW-1:0] r_rad;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [RW+1:0]   rem2;
    logic [RW+1:0]   trial;

    // one digit step
    assign rem2  = {r_rem[RW-1:0], r_rad[2*RW-1 -: 2]};
    assign trial = {r_root, 2'b01};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[2*RW-3:0], 2'b00};
            if (rem2 >= trial) begin
                r_rem  <= rem2 - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem2;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> src/sse_div.sv
// sse_div: restoring unsigned divider, one quotient bit per cycle
// no package dependencies
module sse_div #(
    parameter int W = 41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    trial;

    assign trial = {r_rem, r_quo[W-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem <= W'(trial - {1'b0, r_den});
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/sse_datapath.sv
// sse_datapath: point store, cluster tables, distance and score arithmetic
// depends on sse_pkg, sse_sqrt and sse_div
module sse_datapath
    import sse_pkg::*;
#(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_valid,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic signed [FIELD_W-1:0] i_point_x,
    input  logic signed [FIELD_W-1:0] i_point_y,
    input  logic [LABEL_W-1:0]        i_point_cluster,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic                      o_result_kind,
    output logic [LABEL_W-1:0]        o_cluster_index,
    output logic signed [FIELD_W-1:0] o_score,
    output logic                      o_dropped,
    output logic                      o_last_result
);
    localparam int CW   = COORD_WIDTH;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNW  = $clog2(MAX_POINTS + 1);
    localparam int CIW  = $clog2(MAX_CLUSTERS);
    localparam int NCW  = $clog2(MAX_CLUSTERS + 1);
    localparam int LCW  = (NCW > LABEL_W) ? NCW : LABEL_W;
    localparam int RW   = CW + 9;
    localparam int SUMW = RW + CNW;
    localparam int SSW  = FIELD_W + CNW;
    localparam int TW   = FIELD_W + NCW;
    localparam int DVW  = (SUMW > RW + 15) ? SUMW : RW + 15;
    localparam int MW   = 2 * CW + LABEL_W;

    // point store
    logic [MW-1:0]  mem [MAX_POINTS];
    logic [MW-1:0]  r_rdata;
    logic [AW-1:0]  rd_addr;

    // run state
    logic [CNW-1:0]        r_count;
    logic [CNW-1:0]        r_size [MAX_CLUSTERS];
    logic signed [SSW-1:0] r_ssum [MAX_CLUSTERS];
    logic [SUMW-1:0]       r_sum  [MAX_CLUSTERS];
    logic                  r_drop;
    logic [NCW-1:0]        r_nc;

    // loop state
    logic [CNW-1:0]         r_i;
    logic [CNW-1:0]         r_j;
    logic [NCW-1:0]         r_c;
    logic signed [CW-1:0]   r_xi;
    logic signed [CW-1:0]   r_yi;
    logic [CIW-1:0]         r_own;
    logic [LABEL_W-1:0]     r_labj;
    logic                   r_jvalid;
    logic [CW-1:0]          r_dx;
    logic [CW-1:0]          r_dy;
    logic [2*CW-1:0]        r_dx2;
    logic [2*CW-1:0]        r_dy2;
    logic [RW-1:0]          r_a;
    logic [RW-1:0]          r_b;
    logic                   r_neg;
    logic signed [TW-1:0]   r_total;

    // output register
    logic                      r_out_valid;
    logic                      r_kind;
    logic [LABEL_W-1:0]        r_cidx;
    logic signed [FIELD_W-1:0] r_score;
    logic                      r_odrop;
    logic                      r_last;

    logic signed [CW-1:0]   in_x;
    logic signed [CW-1:0]   in_y;
    logic                   st_ok;
    logic [CIW-1:0]         k;
    logic [CNW-1:0]         sel_size;
    logic [SUMW-1:0]        sel_sum;
    logic signed [SSW-1:0]  sel_ssum;
    logic [SSW-1:0]         abs_ssum;
    logic [TW-1:0]          abs_total;
    logic signed [CW-1:0]   xj;
    logic signed [CW-1:0]   yj;
    logic [LABEL_W-1:0]     rd_label;
    logic signed [CW:0]     dxs;
    logic signed [CW:0]     dys;
    logic [2*RW-1:0]        radicand;
    logic                   sqrt_done;
    logic [RW-1:0]          root;
    logic [DVW-1:0]         dv_n;
    logic [DVW-1:0]         dv_d;
    logic                   dv_neg;
    logic                   div_done;
    logic [DVW-1:0]         quo;
    logic [RW-1:0]          diff;
    logic [RW-1:0]          maxab;
    logic [FIELD_W-1:0]     s_val;
    logic [FIELD_W:0]       q17;
    logic [FIELD_W-1:0]     m_val;
    logic [CFG_W-1:0]       cfg_clamped;

    // incoming coordinates cut to COORD_WIDTH bits, or zero-extended when wider
    generate
        if (CW <= FIELD_W) begin : g_narrow
            assign in_x = i_point_x[CW-1:0];
            assign in_y = i_point_y[CW-1:0];
        end else begin : g_wide
            assign in_x = {{(CW - FIELD_W){1'b0}}, i_point_x};
            assign in_y = {{(CW - FIELD_W){1'b0}}, i_point_y};
        end
    endgenerate

    assign st_ok = (LCW'(i_point_cluster) < LCW'(r_nc)) && (r_count != CNW'(MAX_POINTS));

    // cluster table read index
    always_comb begin
        case (i_cmd.idx_sel)
            IX_IN:   k = CIW'(i_point_cluster);
            IX_OWN:  k = r_own;
            IX_C:    k = CIW'(r_c);
            IX_LABJ: k = CIW'(r_labj);
            default: k = r_own;
        endcase
    end

    assign sel_size  = r_size[k];
    assign sel_sum   = r_sum[k];
    assign sel_ssum  = r_ssum[k];
    assign abs_ssum  = sel_ssum[SSW-1] ? SSW'(-sel_ssum) : SSW'(sel_ssum);
    assign abs_total = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);

    // store fields
    assign xj       = r_rdata[MW-1 -: CW];
    assign yj       = r_rdata[MW-1-CW -: CW];
    assign rd_label = r_rdata[LABEL_W-1:0];
    assign dxs      = $signed({r_xi[CW-1], r_xi}) - $signed({xj[CW-1], xj});
    assign dys      = $signed({r_yi[CW-1], r_yi}) - $signed({yj[CW-1], yj});
    assign rd_addr  = i_cmd.rd_i ? r_i[AW-1:0] : r_j[AW-1:0];

    // point store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && st_ok) begin
            mem[r_count[AW-1:0]] <= {in_x, in_y, i_point_cluster};
        end
        if (i_cmd.rd_i || i_cmd.rd_j) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // configuration register clamped to the legal range
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped = CFG_W'(1);
        end else if (int'(i_cfg_data) > MAX_CLUSTERS) begin
            cfg_clamped = CFG_W'(MAX_CLUSTERS);
        end else begin
            cfg_clamped = i_cfg_data;
        end
    end

    // squared distance radicand with 16 fraction bits
    assign radicand = {1'b0, (2*CW+1)'(r_dx2) + (2*CW+1)'(r_dy2), 16'b0};

    sse_sqrt #(.RW(RW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_go),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // score operands
    assign diff  = (r_b >= r_a) ? r_b - r_a : r_a - r_b;
    assign maxab = (r_a > r_b) ? r_a : r_b;

    // divider operand selection
    always_comb begin
        case (i_cmd.div_sel)
            DV_SUM: begin
                dv_n   = DVW'(sel_sum);
                dv_d   = DVW'(sel_size);
                dv_neg = 1'b0;
            end
            DV_SCORE: begin
                dv_n   = DVW'({diff, 15'b0});
                dv_d   = DVW'(maxab);
                dv_neg = r_a > r_b;
            end
            DV_MEAN: begin
                dv_n   = DVW'(abs_ssum);
                dv_d   = DVW'(sel_size);
                dv_neg = sel_ssum[SSW-1];
            end
            DV_TOTAL: begin
                dv_n   = DVW'(abs_total);
                dv_d   = DVW'(r_nc);
                dv_neg = r_total[TW-1];
            end
            default: begin
                dv_n   = '0;
                dv_d   = '0;
                dv_neg = 1'b0;
            end
        endcase
    end

    sse_div #(.W(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (dv_n),
        .i_divisor  (dv_d),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // point score from the quotient, saturated at plus one
    assign q17 = (FIELD_W+1)'(quo);
    always_comb begin
        if (i_cmd.s_spec) begin
            s_val = (r_nc == NCW'(1)) ? 16'h7fff : '0;
        end else if (r_neg) begin
            s_val = FIELD_W'(-q17);
        end else if (quo > DVW'(32767)) begin
            s_val = 16'h7fff;
        end else begin
            s_val = quo[FIELD_W-1:0];
        end
    end

    // signed mean, truncated toward zero
    always_comb begin
        if (i_cmd.m_zero) begin
            m_val = '0;
        end else if (r_neg) begin
            m_val = FIELD_W'(-q17);
        end else begin
            m_val = quo[FIELD_W-1:0];
        end
    end

    // run state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_nc    <= NCW'(1);
            for (int n = 0; n < MAX_CLUSTERS; n++) begin
                r_size[n] <= '0;
                r_ssum[n] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_nc <= NCW'(cfg_clamped);
            end
            if (i_cmd.run_clr) begin
                r_count <= '0;
                r_drop  <= 1'b0;
                for (int n = 0; n < MAX_CLUSTERS; n++) begin
                    r_size[n] <= '0;
                    r_ssum[n] <= '0;
                end
            end else begin
                if (i_cmd.load) begin
                    if (st_ok) begin
                        r_count  <= r_count + 1'b1;
                        r_size[k] <= sel_size + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                if (i_cmd.s_spec || i_cmd.s_div) begin
                    r_ssum[k] <= sel_ssum + SSW'(signed'(s_val));
                end
            end
        end
    end

    // loop counters and per-pair registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.i_clr) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.j_clr) begin
            r_j <= '0;
            for (int n = 0; n < MAX_CLUSTERS; n++) begin
                r_sum[n] <= '0;
            end
        end else if (i_cmd.acc) begin
            r_j <= r_j + 1'b1;
            if (r_jvalid) begin
                r_sum[k] <= sel_sum + SUMW'(root);
            end
        end
        if (i_cmd.c_clr) begin
            r_c <= '0;
        end else if (i_cmd.c_inc) begin
            r_c <= r_c + 1'b1;
        end
        if (i_cmd.cap_i) begin
            r_xi  <= xj;
            r_yi  <= yj;
            r_own <= CIW'(rd_label);
        end
        if (i_cmd.cap_j) begin
            r_dx     <= dxs[CW] ? CW'(-dxs) : CW'(dxs);
            r_dy     <= dys[CW] ? CW'(-dys) : CW'(dys);
            r_labj   <= rd_label;
            r_jvalid <= LCW'(rd_label) < LCW'(r_nc);
        end
        if (i_cmd.sq) begin
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
        end
        if (i_cmd.div_go) begin
            r_neg <= dv_neg;
        end
        if (i_cmd.a_cap) begin
            r_a <= RW'(quo);
            r_b <= '1;
        end else if (i_cmd.b_zero) begin
            r_b <= '0;
        end else if (i_cmd.b_cap && (RW'(quo) < r_b)) begin
            r_b <= RW'(quo);
        end
        if (i_cmd.tot_clr) begin
            r_total <= '0;
        end else if (i_cmd.m_cap) begin
            r_total <= r_total + TW'(signed'(m_val));
        end
    end

    // result item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.m_cap || i_cmd.t_cap) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_cap) begin
            r_kind  <= 1'b0;
            r_cidx  <= LABEL_W'(r_c);
            r_score <= m_val;
            r_odrop <= r_drop;
            r_last  <= 1'b0;
        end else if (i_cmd.t_cap) begin
            r_kind  <= 1'b1;
            r_cidx  <= '0;
            r_score <= m_val;
            r_odrop <= r_drop;
            r_last  <= 1'b1;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.i_end       = r_i == r_count;
        o_sts.j_end       = r_j == r_count;
        o_sts.c_end       = r_c == r_nc;
        o_sts.own_skip    = LCW'(rd_label) >= LCW'(r_nc);
        o_sts.c_is_own    = CIW'(r_c) == r_own;
        o_sts.c_empty     = sel_size == '0;
        o_sts.one_cluster = r_nc == NCW'(1);
        o_sts.trivial     = (r_a == '0) && (r_b == '0);
        o_sts.sqrt_done   = sqrt_done;
        o_sts.div_done    = div_done;
        o_sts.out_taken   = r_out_valid && !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_cluster_index = r_cidx;
    assign o_score         = r_score;
    assign o_dropped       = r_odrop;
    assign o_last_result   = r_last;

endmodule

>>> src/sse_ctrl.sv
// sse_ctrl: sequencer for loading, the pairwise pass and result output
// depends on sse_pkg
module sse_ctrl
    import sse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_point,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RDI  = 5'd1;
    localparam logic [4:0] ST_CAPI = 5'd2;
    localparam logic [4:0] ST_RDJ  = 5'd3;
    localparam logic [4:0] ST_CAPJ = 5'd4;
    localparam logic [4:0] ST_SQR  = 5'd5;
    localparam logic [4:0] ST_SQGO = 5'd6;
    localparam logic [4:0] ST_SQW  = 5'd7;
    localparam logic [4:0] ST_AGO  = 5'd8;
    localparam logic [4:0] ST_AWT  = 5'd9;
    localparam logic [4:0] ST_BSEL = 5'd10;
    localparam logic [4:0] ST_BWT  = 5'd11;
    localparam logic [4:0] ST_SGO  = 5'd12;
    localparam logic [4:0] ST_SWT  = 5'd13;
    localparam logic [4:0] ST_MGO  = 5'd14;
    localparam logic [4:0] ST_MWT  = 5'd15;
    localparam logic [4:0] ST_MOUT = 5'd16;
    localparam logic [4:0] ST_TGO  = 5'd17;
    localparam logic [4:0] ST_TWT  = 5'd18;
    localparam logic [4:0] ST_TOUT = 5'd19;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.idx_sel = IX_IN;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_point) begin
                        o_cmd.i_clr = 1'b1;
                        n_state     = ST_RDI;
                    end
                end
            end
            // outer loop over stored points
            ST_RDI: begin
                if (i_sts.i_end) begin
                    o_cmd.c_clr   = 1'b1;
                    o_cmd.tot_clr = 1'b1;
                    n_state       = ST_MGO;
                end else begin
                    o_cmd.rd_i = 1'b1;
                    n_state    = ST_CAPI;
                end
            end
            ST_CAPI: begin
                o_cmd.cap_i = 1'b1;
                if (i_sts.own_skip) begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = ST_RDI;
                end else begin
                    o_cmd.j_clr = 1'b1;
                    n_state     = ST_RDJ;
                end
            end
            // inner loop, one distance per pair
            ST_RDJ: begin
                if (i_sts.j_end) begin
                    n_state = ST_AGO;
                end else begin
                    o_cmd.rd_j = 1'b1;
                    n_state    = ST_CAPJ;
                end
            end
            ST_CAPJ: begin
                o_cmd.cap_j = 1'b1;
                n_state     = ST_SQR;
            end
            ST_SQR: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_SQGO;
            end
            ST_SQGO: begin
                o_cmd.sqrt_go = 1'b1;
                n_state       = ST_SQW;
            end
            ST_SQW: begin
                o_cmd.idx_sel = IX_LABJ;
                if (i_sts.sqrt_done) begin
                    o_cmd.acc = 1'b1;
                    n_state   = ST_RDJ;
                end
            end
            // mean distance to own cluster
            ST_AGO: begin
                o_cmd.idx_sel = IX_OWN;
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DV_SUM;
                n_state       = ST_AWT;
            end
            ST_AWT: begin
                if (i_sts.div_done) begin
                    o_cmd.a_cap = 1'b1;
                    o_cmd.c_clr = 1'b1;
                    n_state     = ST_BSEL;
                end
            end
            // least mean distance to other clusters, an empty one giving zero
            ST_BSEL: begin
                o_cmd.idx_sel = IX_C;
                if (i_sts.one_cluster || i_sts.c_end) begin
                    n_state = ST_SGO;
                end else if (i_sts.c_is_own) begin
                    o_cmd.c_inc = 1'b1;
                end else if (i_sts.c_empty) begin
                    o_cmd.b_zero = 1'b1;
                    o_cmd.c_inc  = 1'b1;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DV_SUM;
                    n_state       = ST_BWT;
                end
            end
            ST_BWT: begin
                if (i_sts.div_done) begin
                    o_cmd.b_cap = 1'b1;
                    o_cmd.c_inc = 1'b1;
                    n_state     = ST_BSEL;
                end
            end
            // point score
            ST_SGO: begin
                o_cmd.idx_sel = IX_OWN;
                if (i_sts.one_cluster || i_sts.trivial) begin
                    o_cmd.s_spec = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    n_state      = ST_RDI;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DV_SCORE;
                    n_state       = ST_SWT;
                end
            end
            ST_SWT: begin
                o_cmd.idx_sel = IX_OWN;
                if (i_sts.div_done) begin
                    o_cmd.s_div = 1'b1;
                    o_cmd.i_inc = 1'b1;
                    n_state     = ST_RDI;
                end
            end
            // per-cluster means
            ST_MGO: begin
                o_cmd.idx_sel = IX_C;
                if (i_sts.c_end) begin
                    n_state = ST_TGO;
                end else if (i_sts.c_empty) begin
                    o_cmd.m_cap  = 1'b1;
                    o_cmd.m_zero = 1'b1;
                    o_cmd.c_inc  = 1'b1;
                    n_state      = ST_MOUT;
                end else begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DV_MEAN;
                    n_state       = ST_MWT;
                end
            end
            ST_MWT: begin
                if (i_sts.div_done) begin
                    o_cmd.m_cap = 1'b1;
                    o_cmd.c_inc = 1'b1;
                    n_state     = ST_MOUT;
                end
            end
            ST_MOUT: begin
                if (i_sts.out_taken) begin
                    n_state = ST_MGO;
                end
            end
            // overall mean
            ST_TGO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DV_TOTAL;
                n_state       = ST_TWT;
            end
            ST_TWT: begin
                if (i_sts.div_done) begin
                    o_cmd.t_cap = 1'b1;
                    n_state     = ST_TOUT;
                end
            end
            ST_TOUT: begin
                if (i_sts.out_taken) begin
                    o_cmd.run_clr = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

endmodule

>>> src/sse_checker.sv
// sse_checker: port-level checks on the silhouette score engine
// depends on sse_pkg; bound to silhouette_score_engine below
module sse_checker
    import sse_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      i_last_point,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_result_kind,
    input logic [LABEL_W-1:0]        o_cluster_index,
    input logic signed [FIELD_W-1:0] o_score,
    input logic                      o_last_result
);
    // no item taken while results are pending
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result item is pending");

    // final item starts the pass
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_point) |=> o_in_stall)
        else $error("input not stalled after final item");

    // overall result carries kind one and index zero
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> (o_result_kind && (o_cluster_index == '0)))
        else $error("overall result fields wrong");

    // run ends and input reopens after the overall result
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_result) |=> (!o_in_stall && !o_out_valid))
        else $error("block not idle after the overall result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_score)))
        else $error("stalled result item changed");

endmodule

bind silhouette_score_engine sse_checker u_sse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_last_point    (i_last_point),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_kind   (o_result_kind),
    .o_cluster_index (o_cluster_index),
    .o_score         (o_score),
    .o_last_result   (o_last_result)
);
